// ----- rtl/slrb_pkg.sv -----
// Shared types and constants for the serial line receive buffer.
`default_nettype none

package slrb_pkg;

   // Default store depth in bytes
   localparam int unsigned DEFAULT_DEPTH = 256;

   // Largest fill the 9-bit length limit allows, plus one
   localparam int unsigned FILL_SPAN = 512;

   // Line control characters
   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_LF = 8'd10;

   // Register reset values
   localparam logic [15:0] IDLE_LIMIT_RESET   = 16'd50;
   localparam logic [8:0]  LENGTH_LIMIT_RESET = 9'd256;

   // Idle tick counter saturation value
   localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

   // Register indexes
   localparam logic [1:0] CSR_FRAME_MODE   = 2'd0;
   localparam logic [1:0] CSR_IDLE_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_LENGTH_LIMIT = 2'd2;

   // Frame modes
   localparam logic MODE_TEXT   = 1'b0;
   localparam logic MODE_BINARY = 1'b1;

   // Request commands
   typedef enum logic [2:0] {
      CMD_BYTE  = 3'd0,
      CMD_TICK  = 3'd1,
      CMD_READ  = 3'd2,
      CMD_PEEK  = 3'd3,
      CMD_CLEAR = 3'd4
   } cmd_type;

   // Request payload
   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] rx_data;
      logic [8:0] look_offset;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       frame_done;
      logic       overflowed;
      logic [8:0] fill_count;
      logic [8:0] read_index;
      logic       offset_fits;
   } rsp_type;

   // Store port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/slrb_store.sv -----
// Byte store: one write port and one registered read port.
`default_nettype none

module slrb_store
   import slrb_pkg::*;
#(
   parameter int unsigned Depth = DEFAULT_DEPTH,
   localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic                 clock,
   input  wire store_ctl_type        ctl,
   input  wire logic [AddrW-1:0]     wr_addr,
   input  wire logic [7:0]           wr_data,
   input  wire logic [AddrW-1:0]     rd_addr,
   output      logic [7:0]           rd_data
);

   logic [7:0] mem_ff [Depth];
   logic [7:0] rd_data_ff;

   // Write the new byte, register the read data
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/serial_line_receive_buffer.sv -----
// Top level of the serial line receive buffer.
//
// Requests arrive on req_ (valid/ready) carrying a command: received byte,
// time tick, read next, peek, or clear. Every request yields exactly one
// response on rsp_ with the byte found by read or peek and the buffer
// status after the command. Registers (frame mode, idle limit, length
// limit) are written through csr_, which is always ready; write them only
// while no request is outstanding.
// The response is registered: a request accepted at an edge has its response
// valid after that edge. Throughput is one request per cycle while responses
// are taken, set by the store's single port pair and one-deep response register.
// When the receiver stalls, the response holds and req_ready stays low
// until it is taken; a response taken in the same cycle frees the slot.
// Reset clears the flags, counts and pointers and restores register
// defaults; store contents are not cleared and need no clearing pass, as
// only bytes written since the last clear are ever read back.
`default_nettype none

module serial_line_receive_buffer
   import slrb_pkg::*;
#(
   parameter int unsigned BUFFER_DEPTH = DEFAULT_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      rsp_type     rsp_data,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned StoreDepth = (BUFFER_DEPTH < FILL_SPAN) ? BUFFER_DEPTH : FILL_SPAN;
   localparam int unsigned AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
   localparam logic [16:0] DepthC     = 17'(BUFFER_DEPTH);

   // Registers
   logic        frame_mode_ff;
   logic [15:0] idle_limit_ff;
   logic [8:0]  length_limit_ff;

   // Buffer state
   logic [8:0]  fill_ff,      fill_in;
   logic [8:0]  rd_ptr_ff,    rd_ptr_in;
   logic        done_ff,      done_in;
   logic        overflow_ff,  overflow_in;
   logic [16:0] idle_ff,      idle_in;

   // Response register
   logic        rsp_valid_ff;
   logic        out_valid_ff, out_valid_in;
   logic        fits_ff,      fits_in;

   logic          req_fire;
   store_ctl_type store_ctl;
   logic [9:0]    peek_pos;
   logic [16:0]   idle_inc;
   logic [AddrW-1:0] rd_addr;
   logic [7:0]    rd_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign peek_pos = {1'b0, rd_ptr_ff} + {1'b0, req_data.look_offset};
   assign idle_inc = (idle_ff < IDLE_MAX) ? idle_ff + 17'd1 : idle_ff;

   // Apply one command to the buffer state
   always_comb begin
      fill_in      = fill_ff;
      rd_ptr_in    = rd_ptr_ff;
      done_in      = done_ff;
      overflow_in  = overflow_ff;
      idle_in      = idle_ff;
      out_valid_in = 1'b0;
      store_ctl    = '0;
      rd_addr      = peek_pos[AddrW-1:0];
      unique case (req_data.cmd)
         CMD_BYTE: begin
            if (!done_ff) begin
               idle_in = '0;
               if (frame_mode_ff == MODE_TEXT && req_data.rx_data == CH_CR) begin
                  // drop carriage return
               end else if (frame_mode_ff == MODE_TEXT && req_data.rx_data == CH_LF) begin
                  done_in = 1'b1;
               end else if (fill_ff < length_limit_ff && {8'd0, fill_ff} < DepthC) begin
                  store_ctl.wr_en = req_fire;
                  fill_in         = fill_ff + 9'd1;
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end
         CMD_TICK: begin
            if (!done_ff) begin
               idle_in = idle_inc;
               if (frame_mode_ff == MODE_BINARY && fill_ff != '0 &&
                   idle_inc > {1'b0, idle_limit_ff}) begin
                  done_in = 1'b1;
               end
            end
         end
         CMD_READ: begin
            rd_addr = rd_ptr_ff[AddrW-1:0];
            if (rd_ptr_ff < fill_ff) begin
               out_valid_in    = 1'b1;
               store_ctl.rd_en = req_fire;
               rd_ptr_in       = rd_ptr_ff + 9'd1;
            end
         end
         CMD_PEEK: begin
            if (peek_pos < {1'b0, fill_ff}) begin
               out_valid_in    = 1'b1;
               store_ctl.rd_en = req_fire;
            end
         end
         CMD_CLEAR: begin
            fill_in     = '0;
            rd_ptr_in   = '0;
            done_in     = 1'b0;
            overflow_in = 1'b0;
            idle_in     = '0;
         end
         default: begin
         end
      endcase
      fits_in = ({1'b0, rd_ptr_in} + {1'b0, req_data.look_offset}) <= {1'b0, fill_in};
   end

   // Hold registers, state and response
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff   <= MODE_TEXT;
         idle_limit_ff   <= IDLE_LIMIT_RESET;
         length_limit_ff <= LENGTH_LIMIT_RESET;
         fill_ff         <= '0;
         rd_ptr_ff       <= '0;
         done_ff         <= 1'b0;
         overflow_ff     <= 1'b0;
         idle_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         out_valid_ff    <= 1'b0;
         fits_ff         <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_FRAME_MODE:   frame_mode_ff   <= csr_data[0];
               CSR_IDLE_LIMIT:   idle_limit_ff   <= csr_data;
               CSR_LENGTH_LIMIT: length_limit_ff <= csr_data[8:0];
               default: begin
               end
            endcase
         end
         if (req_fire) begin
            fill_ff      <= fill_in;
            rd_ptr_ff    <= rd_ptr_in;
            done_ff      <= done_in;
            overflow_ff  <= overflow_in;
            idle_ff      <= idle_in;
            out_valid_ff <= out_valid_in;
            fits_ff      <= fits_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   slrb_store #(
      .Depth (StoreDepth)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (fill_ff[AddrW-1:0]),
      .wr_data (req_data.rx_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Drive the response from the held state
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.out_byte    = out_valid_ff ? rd_data : 8'd0;
   assign rsp_data.out_valid   = out_valid_ff;
   assign rsp_data.frame_done  = done_ff;
   assign rsp_data.overflowed  = overflow_ff;
   assign rsp_data.fill_count  = fill_ff;
   assign rsp_data.read_index  = rd_ptr_ff;
   assign rsp_data.offset_fits = fits_ff;

   // Read position never passes the fill level
   a_ptr_in_fill: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff <= fill_ff)
      else $error("read pointer beyond fill level");

   // Frame end flag holds until a clear
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      done_ff && !(req_fire && req_data.cmd == CMD_CLEAR) |=> done_ff)
      else $error("frame done dropped without clear");

   // Fill level only drops on a clear
   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && req_data.cmd == CMD_CLEAR) |=> fill_ff >= $past(fill_ff))
      else $error("fill level dropped without clear");

   // A successful read advances the read position by one
   a_read_adv: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.cmd == CMD_READ && rd_ptr_ff < fill_ff
      |=> rd_ptr_ff == $past(rd_ptr_ff) + 9'd1)
      else $error("read did not advance pointer");

endmodule

`default_nettype wire
